// ===== sv/i2cdw_pkg.sv =====
// Shared types and codes for the display write I2C master.
package i2cdw_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    localparam int         ADDR_W     = 4;
    localparam logic [1:0] REG_DEVICE = 2'd0;
    localparam logic [1:0] REG_ACK_TO = 2'd1;
    localparam logic [1:0] REG_PHASE  = 2'd2;
    localparam logic [7:0] RST_DEVICE = 8'h78;
    localparam logic [7:0] RST_ACK_TO = 8'd250;
    localparam logic [7:0] RST_PHASE  = 8'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] payload_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic sda_drive;
        logic busy_res;
        logic ack_error;
        logic frame_done;
    } out_item_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] ack_timeout;
        logic [7:0] phase_ticks;
    } cfg_t;

endpackage

// ===== sv/i2cdw_regs.sv =====
// Configuration register file behind the APB-style port.
module i2cdw_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cdw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output i2cdw_pkg::cfg_t               cfg
);

    i2cdw_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= i2cdw_pkg::RST_DEVICE;
            cfg_reg.ack_timeout    <= i2cdw_pkg::RST_ACK_TO;
            cfg_reg.phase_ticks    <= i2cdw_pkg::RST_PHASE;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                i2cdw_pkg::REG_DEVICE: cfg_reg.device_address <= pwdata[7:0];
                i2cdw_pkg::REG_ACK_TO: cfg_reg.ack_timeout    <= pwdata[7:0];
                i2cdw_pkg::REG_PHASE:  cfg_reg.phase_ticks    <= pwdata[7:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            i2cdw_pkg::REG_DEVICE: prdata = {24'd0, cfg_reg.device_address};
            i2cdw_pkg::REG_ACK_TO: prdata = {24'd0, cfg_reg.ack_timeout};
            i2cdw_pkg::REG_PHASE:  prdata = {24'd0, cfg_reg.phase_ticks};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/i2cdw_seq.sv =====
// Bus phase sequencer: state registers and the per-item next-state and result logic.
module i2cdw_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  i2cdw_pkg::in_item_t    item,
    input  i2cdw_pkg::cfg_t        cfg,
    output i2cdw_pkg::out_item_t   result
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START     = 4'd1;
    localparam logic [3:0] PH_START_LOW = 4'd2;
    localparam logic [3:0] PH_BIT_SETUP = 4'd3;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd4;
    localparam logic [3:0] PH_BIT_LOW   = 4'd5;
    localparam logic [3:0] PH_ACK_SETUP = 4'd6;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd7;
    localparam logic [3:0] PH_ACK_LOW   = 4'd8;
    localparam logic [3:0] PH_STOP_LOW  = 4'd9;
    localparam logic [3:0] PH_STOP_HIGH = 4'd10;
    localparam logic [3:0] PH_STOP_END  = 4'd11;

    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    logic [3:0] phase_reg,   phase_next;
    logic [1:0] byte_reg,    byte_next;
    logic [2:0] bit_reg,     bit_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] payload_reg, payload_next;
    logic       data_reg,    data_next;
    logic [7:0] ackw_reg,    ackw_next;
    logic [7:0] hold_reg,    hold_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic       err_reg,     err_next;
    logic       done;
    logic       drive;

    // Line levels on entry into a phase; the bit high and low phases keep the data level.
    function automatic logic [1:0] enter_levels(input logic [3:0] ph, input logic msb,
                                                input logic sda_cur);
        logic [1:0] lv;
        case (ph)
            PH_START:     lv = 2'b10;
            PH_START_LOW: lv = 2'b00;
            PH_BIT_SETUP: lv = {1'b0, msb};
            PH_BIT_HIGH:  lv = {1'b1, sda_cur};
            PH_BIT_LOW:   lv = {1'b0, sda_cur};
            PH_ACK_SETUP: lv = 2'b01;
            PH_ACK_HIGH:  lv = 2'b11;
            PH_ACK_LOW:   lv = 2'b01;
            PH_STOP_LOW:  lv = 2'b00;
            PH_STOP_HIGH: lv = 2'b10;
            default:      lv = 2'b11;
        endcase
        return lv;
    endfunction

    always_comb
    begin
        logic       ent;
        logic [3:0] tgt;
        logic [7:0] limit;
        logic [1:0] lv;

        phase_next   = phase_reg;
        byte_next    = byte_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        payload_next = payload_reg;
        data_next    = data_reg;
        ackw_next    = ackw_reg;
        hold_next    = hold_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        err_next     = err_reg;
        done         = 1'b0;
        ent          = 1'b0;
        tgt          = PH_IDLE;
        limit        = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

        if (phase_reg > PH_STOP_END)
        begin
            phase_next = PH_IDLE;
            hold_next  = 8'd0;
            scl_next   = 1'b1;
            sda_next   = 1'b1;
        end

        if (item.command inside {i2cdw_pkg::CMD_WRITE, i2cdw_pkg::CMD_DATA})
        begin
            if (phase_next == PH_IDLE)
            begin
                payload_next = item.payload_byte;
                data_next    = (item.command == i2cdw_pkg::CMD_DATA);
                err_next     = 1'b0;
                byte_next    = 2'd0;
                bit_next     = 3'd0;
                shift_next   = cfg.device_address;
                ent          = 1'b1;
                tgt          = PH_START;
            end
        end
        else if (phase_next != PH_IDLE)
        begin
            if (phase_next == PH_ACK_HIGH)
            begin
                if (!item.sda_in)
                begin
                    ent = 1'b1;
                    tgt = PH_ACK_LOW;
                end
                else
                begin
                    ackw_next = ackw_reg + 8'd1;
                    if (ackw_next >= cfg.ack_timeout)
                    begin
                        err_next = 1'b1;
                        ent      = 1'b1;
                        tgt      = PH_STOP_LOW;
                    end
                end
            end
            else
            begin
                hold_next = hold_next + 8'd1;
                if (hold_next >= limit)
                begin
                    ent = 1'b1;
                    case (phase_next)
                        PH_START:     tgt = PH_START_LOW;
                        PH_START_LOW: tgt = PH_BIT_SETUP;
                        PH_BIT_SETUP: tgt = PH_BIT_HIGH;
                        PH_BIT_HIGH:  tgt = PH_BIT_LOW;
                        PH_BIT_LOW:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 3'd1;
                            tgt        = (bit_next == 3'd0) ? PH_ACK_SETUP : PH_BIT_SETUP;
                        end
                        PH_ACK_SETUP: tgt = PH_ACK_HIGH;
                        PH_ACK_LOW:
                        begin
                            byte_next = byte_reg + 2'd1;
                            if (byte_next == 2'd1)
                            begin
                                shift_next = data_reg ? CTRL_DATA : CTRL_COMMAND;
                                bit_next   = 3'd0;
                                tgt        = PH_BIT_SETUP;
                            end
                            else if (byte_next == 2'd2)
                            begin
                                shift_next = payload_reg;
                                bit_next   = 3'd0;
                                tgt        = PH_BIT_SETUP;
                            end
                            else
                            begin
                                tgt = PH_STOP_LOW;
                            end
                        end
                        PH_STOP_LOW:  tgt = PH_STOP_HIGH;
                        PH_STOP_HIGH: tgt = PH_STOP_END;
                        PH_STOP_END:
                        begin
                            tgt  = PH_IDLE;
                            done = 1'b1;
                        end
                        default:      tgt = PH_IDLE;
                    endcase
                end
            end
        end

        lv = enter_levels(tgt, shift_next[7], sda_next);
        if (ent)
        begin
            phase_next = tgt;
            hold_next  = 8'd0;
            scl_next   = lv[1];
            sda_next   = lv[0];
            if (tgt == PH_ACK_SETUP)
            begin
                ackw_next = 8'd0;
            end
        end
    end

    assign drive = !(phase_next inside {PH_ACK_SETUP, PH_ACK_HIGH, PH_ACK_LOW});

    assign result.scl_level  = scl_next;
    assign result.sda_level  = drive ? sda_next : 1'b1;
    assign result.sda_drive  = drive;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.ack_error  = err_next;
    assign result.frame_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            byte_reg    <= 2'd0;
            bit_reg     <= 3'd0;
            shift_reg   <= 8'd0;
            payload_reg <= 8'd0;
            data_reg    <= 1'b0;
            ackw_reg    <= 8'd0;
            hold_reg    <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            err_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            byte_reg    <= byte_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            payload_reg <= payload_next;
            data_reg    <= data_next;
            ackw_reg    <= ackw_next;
            hold_reg    <= hold_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== sv/i2c_display_write_master_unit.sv =====
// Top level of the write-only display I2C master: input register, sequencer, result queue.
// An accepted input item is held in the input register, and its result is registered into the result queue.
// Throughput: one item per cycle while the result queue is not full; each item advances the bus sequencer by one step.
// A two-entry result queue lets input items keep flowing while one result waits.
// Reset: the sequencer returns to the idle bus with SCL and SDA high, the queue empties, and the registers
// take their reset values at once; no clearing pass is needed.
module i2c_display_write_master_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  i2cdw_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output i2cdw_pkg::out_item_t          out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cdw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    i2cdw_pkg::cfg_t      cfg;
    i2cdw_pkg::in_item_t  item_reg;
    i2cdw_pkg::out_item_t result;
    i2cdw_pkg::out_item_t head_reg;
    i2cdw_pkg::out_item_t skid_reg;
    logic                 item_valid_reg;
    logic                 head_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_take;
    logic                 fire;
    logic                 pop;

    assign in_stall  = item_valid_reg && skid_valid_reg;
    assign in_take   = in_valid && !in_stall;
    assign fire      = item_valid_reg && !skid_valid_reg;
    assign pop       = head_valid_reg && !out_stall;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

    i2cdw_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cdw_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end

            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (fire)
            begin
                if (!head_valid_reg || pop)
                begin
                    head_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (fire)
        begin
            if (!head_valid_reg || pop)
            begin
                head_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

endmodule

// ===== bench/i2c_display_write_master_unit_tb.sv =====
// Self-checking testbench for the display write I2C master: directed table, then random frames.
module i2c_display_write_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cdw_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [7:0] CTRL_CMD_BYTE = 8'h00;
    localparam logic [7:0] CTRL_DATA_BYTE = 8'h40;

    localparam logic [ADDR_W-1:0] ADDR_DEVICE = {REG_DEVICE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_ACK_TO = {REG_ACK_TO, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_PHASE = {REG_PHASE, 2'b00};

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIR_ROWS = 25;

    typedef enum logic [3:0] {
        BUS_IDLE, BUS_START, BUS_START_LOW, BUS_BIT_SETUP, BUS_BIT_HIGH, BUS_BIT_LOW,
        BUS_ACK_SETUP, BUS_ACK_HIGH, BUS_ACK_LOW, BUS_STOP_LOW, BUS_STOP_HIGH, BUS_STOP_END
    } bus_phase_e;

    typedef enum logic [1:0] {ACK_MOSTLY, ACK_ALWAYS, ACK_REFUSE_ONE} ack_plan_e;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } step_row_t;

    localparam out_item_t PINS_PREDICTED = '0;
    localparam out_item_t PINS_IDLE =
        '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
          busy_res: 1'b0, ack_error: 1'b0, frame_done: 1'b0};
    localparam out_item_t PINS_START =
        '{scl_level: 1'b1, sda_level: 1'b0, sda_drive: 1'b1,
          busy_res: 1'b1, ack_error: 1'b0, frame_done: 1'b0};
    localparam out_item_t PINS_START_LOW =
        '{scl_level: 1'b0, sda_level: 1'b0, sda_drive: 1'b1,
          busy_res: 1'b1, ack_error: 1'b0, frame_done: 1'b0};

    localparam step_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{'{CMD_TICK,  8'h00, 1'b0}, 1'b1, PINS_IDLE},
        '{'{CMD_SPARE, 8'hFF, 1'b1}, 1'b1, PINS_IDLE},
        '{'{CMD_WRITE, 8'hFF, 1'b1}, 1'b1, PINS_START},
        '{'{CMD_DATA,  8'h00, 1'b0}, 1'b1, PINS_START},
        '{'{CMD_WRITE, 8'h55, 1'b1}, 1'b1, PINS_START},
        '{'{CMD_TICK,  8'hAA, 1'b1}, 1'b1, PINS_START_LOW},
        '{'{CMD_TICK,  8'h00, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_SPARE, 8'hFF, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h0F, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'hF0, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_DATA,  8'h81, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h7E, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_SPARE, 8'h00, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'hFF, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h12, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h34, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_WRITE, 8'h00, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h56, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_SPARE, 8'h78, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h9A, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'hBC, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'hDE, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'hFF, 1'b1}, 1'b0, PINS_PREDICTED},
        '{'{CMD_SPARE, 8'h01, 1'b0}, 1'b0, PINS_PREDICTED},
        '{'{CMD_TICK,  8'h80, 1'b1}, 1'b0, PINS_PREDICTED}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_stall;
    out_item_t           out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    out_item_t  expected_pins [$];
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         feed_calm = 0;
    int         drain_calm = 0;

    cfg_t       cfg_model;
    bus_phase_e bus_phase;
    logic [1:0] byte_sel;
    logic [2:0] bit_cnt;
    logic [7:0] shift_reg;
    logic [7:0] payload_reg;
    logic       data_frame;
    logic [7:0] ack_waits;
    logic [7:0] hold_cnt;
    logic       scl_q;
    logic       sda_q;
    logic       err_q;
    ack_plan_e  ack_plan;
    logic [1:0] refused_byte;

    i2c_display_write_master_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void enter_phase(bus_phase_e ph);
        bus_phase = ph;
        hold_cnt = 8'd0;
        case (ph)
            BUS_START:
            begin
                scl_q = 1'b1;
                sda_q = 1'b0;
            end
            BUS_START_LOW, BUS_STOP_LOW:
            begin
                scl_q = 1'b0;
                sda_q = 1'b0;
            end
            BUS_BIT_SETUP:
            begin
                scl_q = 1'b0;
                sda_q = shift_reg[7];
            end
            BUS_BIT_HIGH:
                scl_q = 1'b1;
            BUS_BIT_LOW:
                scl_q = 1'b0;
            BUS_ACK_SETUP:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                ack_waits = 8'd0;
            end
            BUS_ACK_HIGH:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
            end
            BUS_ACK_LOW:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end
            BUS_STOP_HIGH:
            begin
                scl_q = 1'b1;
                sda_q = 1'b0;
            end
            default:
            begin
                bus_phase = BUS_IDLE;
                scl_q = 1'b1;
                sda_q = 1'b1;
            end
        endcase
    endfunction

    function automatic void load_next_byte();
        byte_sel = byte_sel + 2'd1;
        if (byte_sel == 2'd1)
        begin
            shift_reg = data_frame ? CTRL_DATA_BYTE : CTRL_CMD_BYTE;
            bit_cnt = 3'd0;
            enter_phase(BUS_BIT_SETUP);
        end
        else if (byte_sel == 2'd2)
        begin
            shift_reg = payload_reg;
            bit_cnt = 3'd0;
            enter_phase(BUS_BIT_SETUP);
        end
        else
            enter_phase(BUS_STOP_LOW);
    endfunction

    function automatic logic advance_bus(logic sda_sample);
        logic [7:0] limit;
        limit = (cfg_model.phase_ticks == 8'd0) ? 8'd1 : cfg_model.phase_ticks;
        if (bus_phase == BUS_ACK_HIGH)
        begin
            if (!sda_sample)
                enter_phase(BUS_ACK_LOW);
            else
            begin
                ack_waits = ack_waits + 8'd1;
                if (ack_waits >= cfg_model.ack_timeout)
                begin
                    err_q = 1'b1;
                    enter_phase(BUS_STOP_LOW);
                end
            end
            return 1'b0;
        end
        hold_cnt = hold_cnt + 8'd1;
        if (hold_cnt < limit)
            return 1'b0;
        case (bus_phase)
            BUS_START:     enter_phase(BUS_START_LOW);
            BUS_START_LOW: enter_phase(BUS_BIT_SETUP);
            BUS_BIT_SETUP: enter_phase(BUS_BIT_HIGH);
            BUS_BIT_HIGH:  enter_phase(BUS_BIT_LOW);
            BUS_BIT_LOW:
            begin
                shift_reg = shift_reg << 1;
                bit_cnt = bit_cnt + 3'd1;
                enter_phase(bit_cnt == 3'd0 ? BUS_ACK_SETUP : BUS_BIT_SETUP);
            end
            BUS_ACK_SETUP: enter_phase(BUS_ACK_HIGH);
            BUS_ACK_LOW:   load_next_byte();
            BUS_STOP_LOW:  enter_phase(BUS_STOP_HIGH);
            BUS_STOP_HIGH:
            begin
                enter_phase(BUS_IDLE);
                bus_phase = BUS_STOP_END;
            end
            BUS_STOP_END:
            begin
                enter_phase(BUS_IDLE);
                return 1'b1;
            end
            default:       enter_phase(BUS_IDLE);
        endcase
        return 1'b0;
    endfunction

    function automatic out_item_t predict_bus_item(in_item_t it, output logic ignored);
        out_item_t pins;
        logic      done;
        logic      drive;
        done = 1'b0;
        ignored = 1'b0;
        if (it.command == CMD_WRITE || it.command == CMD_DATA)
        begin
            if (bus_phase == BUS_IDLE)
            begin
                payload_reg = it.payload_byte;
                data_frame = (it.command == CMD_DATA);
                err_q = 1'b0;
                byte_sel = 2'd0;
                bit_cnt = 3'd0;
                shift_reg = cfg_model.device_address;
                enter_phase(BUS_START);
            end
            else
                ignored = 1'b1;
        end
        else if (bus_phase != BUS_IDLE)
            done = advance_bus(it.sda_in);
        else
            ignored = 1'b1;
        drive = !(bus_phase == BUS_ACK_SETUP || bus_phase == BUS_ACK_HIGH ||
                  bus_phase == BUS_ACK_LOW);
        pins.scl_level = scl_q;
        pins.sda_level = drive ? sda_q : 1'b1;
        pins.sda_drive = drive;
        pins.busy_res = (bus_phase != BUS_IDLE);
        pins.ack_error = err_q;
        pins.frame_done = done;
        return pins;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            calm = $urandom_range(40, 160);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic ack_sample();
        case (ack_plan)
            ACK_ALWAYS:     return 1'b0;
            ACK_REFUSE_ONE: return (byte_sel == refused_byte);
            default:        return ($urandom_range(0, 99) >= 60);
        endcase
    endfunction

    // Mostly well-formed frames; requests during a frame and ticks on an idle bus are noise.
    function automatic in_item_t pick_item();
        in_item_t it;
        int       r;
        it.payload_byte = 8'($urandom);
        it.sda_in = 1'($urandom);
        r = $urandom_range(0, 99);
        if (bus_phase == BUS_IDLE)
        begin
            if (r < 85)
            begin
                it.command = (r < 42) ? CMD_WRITE : CMD_DATA;
                r = $urandom_range(0, 99);
                ack_plan = (r < 60) ? ACK_MOSTLY : (r < 85) ? ACK_ALWAYS : ACK_REFUSE_ONE;
                refused_byte = 2'($urandom_range(0, 2));
            end
            else
                it.command = (r < 92) ? CMD_TICK : CMD_SPARE;
        end
        else if (r < 4)
            it.command = (r < 2) ? CMD_WRITE : CMD_DATA;
        else
        begin
            it.command = (r < 18) ? CMD_SPARE : CMD_TICK;
            if (bus_phase == BUS_ACK_HIGH)
                it.sda_in = ack_sample();
        end
        return it;
    endfunction

    task automatic check_pins(out_item_t want, out_item_t got);
        if (got.scl_level !== want.scl_level)
        begin
            $error("scl_level: expected %0b, got %0b", want.scl_level, got.scl_level);
            fail_count++;
        end
        if (got.sda_level !== want.sda_level)
        begin
            $error("sda_level: expected %0b, got %0b", want.sda_level, got.sda_level);
            fail_count++;
        end
        if (got.sda_drive !== want.sda_drive)
        begin
            $error("sda_drive: expected %0b, got %0b", want.sda_drive, got.sda_drive);
            fail_count++;
        end
        if (got.busy_res !== want.busy_res)
        begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            fail_count++;
        end
        if (got.ack_error !== want.ack_error)
        begin
            $error("ack_error: expected %0b, got %0b", want.ack_error, got.ack_error);
            fail_count++;
        end
        if (got.frame_done !== want.frame_done)
        begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            fail_count++;
        end
    endtask

    task automatic send(in_item_t it, logic typed, out_item_t want, output logic ignored);
        out_item_t pins;
        int        gap;
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pins = predict_bus_item(it, ignored);
        expected_pins.push_back(typed ? want : pins);
        gap = pick_gap(feed_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (addr)
            ADDR_DEVICE: cfg_model.device_address = value;
            ADDR_ACK_TO: cfg_model.ack_timeout = value;
            default:     cfg_model.phase_ticks = value;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            $error("prdata: expected %h, got %h", {24'd0, value}, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic finish_frame();
        in_item_t it;
        logic     ignored;
        while (bus_phase != BUS_IDLE)
        begin
            it.command = CMD_TICK;
            it.payload_byte = 8'($urandom);
            it.sda_in = (bus_phase == BUS_ACK_HIGH) ? 1'b0 : 1'($urandom);
            send(it, 1'b0, PINS_PREDICTED, ignored);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] dev, logic [7:0] ack_to, logic [7:0] ticks,
                             int budget);
        in_item_t it;
        logic     ignored;
        int       used;
        write_reg(ADDR_DEVICE, dev);
        write_reg(ADDR_ACK_TO, ack_to);
        write_reg(ADDR_PHASE, ticks);
        used = 0;
        while (used < budget)
        begin
            it = pick_item();
            send(it, 1'b0, PINS_PREDICTED, ignored);
            if (!ignored)
                used++;
        end
        finish_frame();
        settle();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pins.size() == 0)
            begin
                $error("result item with nothing expected: %p", out_item);
                fail_count++;
            end
            else
                check_pins(expected_pins.pop_front(), out_item);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n = pick_gap(drain_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic ignored;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_model = '{device_address: RST_DEVICE, ack_timeout: RST_ACK_TO,
                      phase_ticks: RST_PHASE};
        bus_phase = BUS_IDLE;
        byte_sel = 2'd0;
        bit_cnt = 3'd0;
        shift_reg = 8'd0;
        payload_reg = 8'd0;
        data_frame = 1'b0;
        ack_waits = 8'd0;
        hold_cnt = 8'd0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        err_q = 1'b0;
        ack_plan = ACK_ALWAYS;
        refused_byte = 2'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want, ignored);
        finish_frame();
        settle();

        run_phase(8'h00, 8'd1, 8'd1, 140);
        run_phase(8'hFF, 8'd255, 8'd2, 140);
        run_phase(8'($urandom), 8'd0, 8'd0, 120);
        run_phase(8'($urandom), 8'd3, 8'd3, 140);
        run_phase(8'($urandom), 8'($urandom_range(1, 20)), 8'd1, 140);
        run_phase(8'($urandom), 8'($urandom_range(1, 8)), 8'd4, 60);
        run_phase(RST_DEVICE, RST_ACK_TO, RST_PHASE, 110);
        run_phase(8'($urandom), 8'd2, 8'($urandom_range(1, 4)), 140);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
